FILE: rtl/psl_pkg.sv
package psl_pkg;

  // Function codes of an input transaction
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_REKEY = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } psl_func_e;

  // Status codes of a result transaction
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANK    = 2'd3
  } psl_status_e;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } psl_op_e;

  // Status a cell hands to its right-hand neighbour
  typedef struct packed {
    logic valid;  // cell lies inside the occupied part of the list
    logic gt;     // cell sorts after the broadcast entry
  } psl_link_t;

endpackage

FILE: rtl/psl_cell.sv
module psl_cell #(
  parameter int ID_BITS  = 10,
  parameter int KEY_BITS = 16,
  parameter int CNT_BITS = 11,
  parameter int INDEX    = 0
) (
  input  logic                       clk_i,
  input  psl_pkg::psl_op_e           op_i,
  input  logic [ID_BITS-1:0]         bc_id_i,
  input  logic [KEY_BITS-1:0]        bc_key_i,
  input  logic [CNT_BITS-1:0]        bc_n_i,
  input  logic [ID_BITS-1:0]         bc_rank_i,
  input  psl_pkg::psl_link_t         link_i,
  input  logic [ID_BITS-1:0]         left_id_i,
  input  logic [KEY_BITS-1:0]        left_key_i,
  input  logic [ID_BITS-1:0]         right_id_i,
  input  logic [KEY_BITS-1:0]        right_key_i,
  output psl_pkg::psl_link_t         link_o,
  output logic [ID_BITS-1:0]         id_o,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [ID_BITS+KEY_BITS-1:0] hit_o
);

  localparam logic [CNT_BITS-1:0] SLOT_CNT = CNT_BITS'(INDEX);
  localparam logic [ID_BITS-1:0]  SLOT     = ID_BITS'(INDEX);

  logic [ID_BITS-1:0]  id_q;
  logic [KEY_BITS-1:0] key_q;
  logic                valid;
  logic                later;
  logic                same;
  logic                gt;
  logic                ge;

  assign valid = SLOT_CNT < bc_n_i;
  // ascending key, ties by ascending id
  assign later = (key_q > bc_key_i) || ((key_q == bc_key_i) && (id_q > bc_id_i));
  assign same  = (key_q == bc_key_i) && (id_q == bc_id_i);
  assign gt    = valid && later;
  assign ge    = valid && (later || same);

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      psl_pkg::OP_INSERT: begin
        if (link_i.gt) begin
          id_q  <= left_id_i;
          key_q <= left_key_i;
        end else if (gt || (!valid && link_i.valid)) begin
          id_q  <= bc_id_i;
          key_q <= bc_key_i;
        end
      end
      psl_pkg::OP_REMOVE: begin
        if (ge) begin
          id_q  <= right_id_i;
          key_q <= right_key_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign link_o = '{valid: valid, gt: gt};
  assign id_o   = id_q;
  assign key_o  = key_q;
  assign hit_o  = (bc_rank_i == SLOT) ? {id_q, key_q} : '0;

endmodule

FILE: rtl/psl_or_tree.sv
module psl_or_tree #(
  parameter int N      = 1024,
  parameter int W      = 26,
  parameter int LEVELS = 4
) (
  input  logic                clk_i,
  input  logic [N-1:0][W-1:0] data_i,
  output logic [W-1:0]        data_o
);

  // eight-way OR per node, one register level per tree level
  logic [W-1:0] lvl_q [1:LEVELS][N];

  for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
    localparam int NK     = (N + 8**k - 1) / (8**k);
    localparam int PREV_N = (N + 8**(k-1) - 1) / (8**(k-1));

    always_ff @(posedge clk_i) begin
      logic [W-1:0] acc;
      for (int j = 0; j < N; j++) begin
        acc = '0;
        if (j < NK) begin
          for (int c = 0; c < 8; c++) begin
            if (8 * j + c < PREV_N) begin
              if (k == 1) begin
                acc = acc | data_i[8 * j + c];
              end else begin
                acc = acc | lvl_q[(k > 1) ? k - 1 : 1][8 * j + c];
              end
            end
          end
        end
        lvl_q[k][j] <= acc;
      end
    end
  end

  assign data_o = lvl_q[LEVELS][0];

endmodule

FILE: rtl/price_sorted_id_list.sv
// Channel | Direction | Handshake                    | Payload
// in      | into      | in_valid_i / in_stall_o      | func_i, entry_id_i, key_value_i, rank_i
// out     | out of    | out_valid_o / out_stall_i    | result_id_o, result_key_o,
//         |           |                              | entry_count_o, status_o
//
// Flow: one transaction at a time. Add makes an insert pass, rekey a remove pass,
//   then an insert pass through the cell chain; read does a rank lookup through the
//   registered eight-way OR tree (TREE_LEVELS = ceil(log2(DEPTH)/3), 4 at DEPTH 1024);
//   rejected or undefined requests go straight to the response state.
// Reset: asynchronous, active low; clears the entry count, state and output valid.
//   The cells and the key store are not cleared; nothing reads them before writing.
// Stalls: the output register frees the input side, the next transaction is taken
//   while a result waits; a finished operation holds until the output register frees.
module price_sorted_id_list #(
  parameter int DEPTH    = 1024,
  parameter int KEY_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [$clog2(DEPTH)-1:0]    entry_id_i,
  input  logic [KEY_BITS-1:0]         key_value_i,
  input  logic [$clog2(DEPTH)-1:0]    rank_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [$clog2(DEPTH)-1:0]    result_id_o,
  output logic [KEY_BITS-1:0]         result_key_o,
  output logic [$clog2(DEPTH+1)-1:0]  entry_count_o,
  output logic [1:0]                  status_o
);

  localparam int ID_BITS     = $clog2(DEPTH);
  localparam int CNT_BITS    = $clog2(DEPTH + 1);
  localparam int W           = ID_BITS + KEY_BITS;
  localparam int TREE_LEVELS = ($clog2(DEPTH) + 2) / 3;
  localparam int RC_BITS     = $clog2(TREE_LEVELS + 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);
  localparam logic [RC_BITS-1:0]  RD_LAST  = RC_BITS'(TREE_LEVELS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REMOVE = 5'b00010,
    S_INSERT = 5'b00100,
    S_READ   = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [RC_BITS-1:0]    rd_cnt_q, rd_cnt_d;

  // operation registers, loaded on an accepted transaction
  logic                  op_add_q, op_add_d;
  logic [ID_BITS-1:0]    op_id_q, op_id_d;
  logic [KEY_BITS-1:0]   op_key_q, op_key_d;
  logic [ID_BITS-1:0]    op_rank_q, op_rank_d;
  psl_pkg::psl_status_e  op_st_q, op_st_d;

  // key per id; only needed to find an entry before it is removed
  logic [KEY_BITS-1:0]   key_store [DEPTH];
  logic [KEY_BITS-1:0]   old_key_q;
  logic                  ks_we;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [ID_BITS-1:0]    res_id_q, res_id_d;
  logic [KEY_BITS-1:0]   res_key_q, res_key_d;
  logic [CNT_BITS-1:0]   res_cnt_q, res_cnt_d;
  psl_pkg::psl_status_e  res_st_q, res_st_d;
  logic                  load_out;

  // chain broadcast
  psl_pkg::psl_op_e      cell_op;
  logic [ID_BITS-1:0]    bc_id;
  logic [KEY_BITS-1:0]   bc_key;
  logic [CNT_BITS-1:0]   bc_n;

  logic [ID_BITS-1:0]    cell_id  [DEPTH];
  logic [KEY_BITS-1:0]   cell_key [DEPTH];
  psl_pkg::psl_link_t    cell_link [DEPTH];
  logic [DEPTH-1:0][W-1:0] hit_w;
  logic [W-1:0]          tree_w;

  logic                  in_accept;
  logic                  slot_free;
  psl_pkg::psl_func_e    func;

  assign in_accept = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign func      = psl_pkg::psl_func_e'(func_i);
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_cnt_d  = rd_cnt_q;
    op_add_d  = op_add_q;
    op_id_d   = op_id_q;
    op_key_d  = op_key_q;
    op_rank_d = op_rank_q;
    op_st_d   = op_st_q;
    cell_op   = psl_pkg::OP_HOLD;
    bc_id     = op_id_q;
    bc_key    = op_key_q;
    bc_n      = count_q;
    ks_we     = 1'b0;
    load_out  = 1'b0;
    res_id_d  = op_id_q;
    res_key_d = '0;
    res_cnt_d = count_q;
    res_st_d  = op_st_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_key_d  = key_value_i;
          op_rank_d = rank_i;
          op_st_d   = psl_pkg::ST_OK;
          op_id_d   = '0;
          rd_cnt_d  = '0;
          unique case (func)
            psl_pkg::FUNC_ADD: begin
              op_add_d = 1'b1;
              if (count_q == FULL_CNT) begin
                op_st_d = psl_pkg::ST_FULL;
                state_d = S_RESP;
              end else begin
                op_id_d = count_q[ID_BITS-1:0];
                state_d = S_INSERT;
              end
            end
            psl_pkg::FUNC_REKEY: begin
              op_add_d = 1'b0;
              op_id_d  = entry_id_i;
              if (CNT_BITS'(entry_id_i) >= count_q) begin
                op_st_d = psl_pkg::ST_UNKNOWN;
                state_d = S_RESP;
              end else begin
                state_d = S_REMOVE;
              end
            end
            psl_pkg::FUNC_READ: begin
              if (CNT_BITS'(rank_i) >= count_q) begin
                op_st_d = psl_pkg::ST_RANK;
                state_d = S_RESP;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_REMOVE: begin
        // old key and id locate the entry; cells at or behind it pull from the right
        cell_op = psl_pkg::OP_REMOVE;
        bc_key  = old_key_q;
        state_d = S_INSERT;
      end
      S_INSERT: begin
        if (slot_free) begin
          cell_op   = psl_pkg::OP_INSERT;
          bc_n      = op_add_q ? count_q : count_q - CNT_BITS'(1);
          ks_we     = 1'b1;
          count_d   = op_add_q ? count_q + CNT_BITS'(1) : count_q;
          load_out  = 1'b1;
          res_key_d = op_key_q;
          res_cnt_d = count_d;
          state_d   = S_IDLE;
        end
      end
      S_READ: begin
        if (rd_cnt_q == RD_LAST) begin
          if (slot_free) begin
            load_out  = 1'b1;
            res_id_d  = tree_w[W-1:KEY_BITS];
            res_key_d = tree_w[KEY_BITS-1:0];
            state_d   = S_IDLE;
          end
        end else begin
          rd_cnt_d = rd_cnt_q + RC_BITS'(1);
        end
      end
      S_RESP: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_add_q  <= op_add_d;
    op_id_q   <= op_id_d;
    op_key_q  <= op_key_d;
    op_rank_q <= op_rank_d;
    op_st_q   <= op_st_d;
    if (load_out) begin
      res_id_q  <= res_id_d;
      res_key_q <= res_key_d;
      res_cnt_q <= res_cnt_d;
      res_st_q  <= res_st_d;
    end
  end

  // key store: written on insert, read at the incoming id on accept
  always_ff @(posedge clk_i) begin
    if (ks_we) begin
      key_store[op_id_q] <= op_key_q;
    end
    if (in_accept) begin
      old_key_q <= key_store[entry_id_i];
    end
  end

  // the sorted list: one cell per rank
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    psl_pkg::psl_link_t  link_in;
    logic [ID_BITS-1:0]  left_id, right_id;
    logic [KEY_BITS-1:0] left_key, right_key;

    if (i == 0) begin : g_first
      assign link_in  = '{valid: 1'b1, gt: 1'b0};
      assign left_id  = bc_id;
      assign left_key = bc_key;
    end else begin : g_mid
      assign link_in  = cell_link[i-1];
      assign left_id  = cell_id[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_id  = cell_id[i];
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_id  = cell_id[i+1];
      assign right_key = cell_key[i+1];
    end

    psl_cell #(
      .ID_BITS  (ID_BITS),
      .KEY_BITS (KEY_BITS),
      .CNT_BITS (CNT_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .bc_id_i     (bc_id),
      .bc_key_i    (bc_key),
      .bc_n_i      (bc_n),
      .bc_rank_i   (op_rank_q),
      .link_i      (link_in),
      .left_id_i   (left_id),
      .left_key_i  (left_key),
      .right_id_i  (right_id),
      .right_key_i (right_key),
      .link_o      (cell_link[i]),
      .id_o        (cell_id[i]),
      .key_o       (cell_key[i]),
      .hit_o       (hit_w[i])
    );
  end

  // rank lookup: exactly one cell drives its entry, the tree ORs them together
  psl_or_tree #(
    .N      (DEPTH),
    .W      (W),
    .LEVELS (TREE_LEVELS)
  ) u_tree (
    .clk_i  (clk_i),
    .data_i (hit_w),
    .data_o (tree_w)
  );

  assign out_valid_o   = out_valid_q;
  assign result_id_o   = res_id_q;
  assign result_key_o  = res_key_q;
  assign entry_count_o = res_cnt_q;
  assign status_o      = res_st_q;

  // entry count never passes the list depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("entry count beyond depth");

  // the count only moves on an add that completes its insert pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(state_q == S_INSERT && op_add_q))
    else $error("entry count changed outside an add");

  // a fresh result only appears as an operation finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q != S_IDLE) && state_q == S_IDLE)
    else $error("result without a finishing operation");

  // a full-list result reports a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_st_q == psl_pkg::ST_FULL) |-> res_cnt_q == FULL_CNT)
    else $error("full status with room left");

  // a rank lookup is only started inside the occupied list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> CNT_BITS'(op_rank_q) < count_q)
    else $error("rank lookup outside the list");

endmodule
